// File: rtl/core/ebs_pkg.sv
`timescale 1ns / 1ps

package ebs_pkg;

	localparam int COL_W = 6;
	localparam int LEN_W = 7;
	localparam int ROWIDX_W = 10;
	localparam int VAL_W = 16;
	localparam int SUM_W = 32;

	localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = 7'd16;

	typedef enum logic [1:0] {
		OP_WRITE     = 2'd0,
		OP_ADD       = 2'd1,
		OP_ADD_CLOSE = 2'd2,
		OP_CLOSE     = 2'd3
	} opcode_t;

	typedef struct packed {
		logic             rd;
		logic             add;
		logic             clear;
		logic [COL_W-1:0] col;
	} acc_cmd_t;

endpackage

// File: rtl/core/ebs_if.sv
`timescale 1ns / 1ps

interface ebs_item_if;
	import ebs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [1:0]            opcode;
	logic [ROWIDX_W-1:0]   row_index;
	logic [COL_W-1:0]      column;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output opcode, output row_index, output column,
		output value, input ready);
	modport sink (input valid, input opcode, input row_index, input column,
		input value, output ready);
endinterface

interface ebs_result_if;
	import ebs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] sum;
	logic [COL_W-1:0]        column_res;
	logic                    last;

	modport source (output valid, output sum, output column_res, output last,
		input ready);
	modport sink (input valid, input sum, input column_res, input last,
		output ready);
endinterface

// File: rtl/core/ebs_table_mem.sv
`timescale 1ns / 1ps

module ebs_table_mem #(
	parameter int DEPTH = 16384,
	parameter int ADDR_W = 14
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [ADDR_W-1:0]        wr_addr,
	input  logic signed [15:0]       wr_data,
	input  logic                     rd_en,
	input  logic [ADDR_W-1:0]        rd_addr,
	output logic signed [15:0]       rd_data
);

	logic signed [15:0] mem [DEPTH];
	logic signed [15:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/ebs_accum.sv
`timescale 1ns / 1ps

module ebs_accum #(
	parameter int ROW_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ebs_pkg::acc_cmd_t                 cmd,
	input  logic signed [ebs_pkg::VAL_W-1:0]  tbl_data,
	output logic signed [ebs_pkg::SUM_W-1:0]  acc_value
);
	import ebs_pkg::*;

	localparam int AW = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;

	logic signed [SUM_W-1:0] mem [ROW_WIDTH];
	logic signed [SUM_W-1:0] rd_q;
	logic [ROW_WIDTH-1:0]    vld_q;
	logic                    vld_s1;
	logic                    add_s1;
	logic [AW-1:0]           col_s1;
	logic signed [SUM_W:0]   wide_sum;
	logic signed [SUM_W-1:0] sat_sum;

	assign acc_value = vld_s1 ? rd_q : '0;

	// The single saturating adder serves every element of every lookup.
	always_comb begin
		wide_sum = {acc_value[SUM_W-1], acc_value}
			+ {{(SUM_W + 1 - VAL_W){tbl_data[VAL_W-1]}}, tbl_data};
		if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
			sat_sum = wide_sum[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
				: {1'b0, {(SUM_W - 1){1'b1}}};
		end else begin
			sat_sum = wide_sum[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= mem[cmd.col[AW-1:0]];
			col_s1 <= cmd.col[AW-1:0];
		end
		if (add_s1) begin
			mem[col_s1] <= sat_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vld_s1 <= 1'b0;
			add_s1 <= 1'b0;
		end else begin
			add_s1 <= cmd.rd && cmd.add;
			if (cmd.rd) begin
				vld_s1 <= vld_q[cmd.col[AW-1:0]];
			end
			if (cmd.clear) begin
				vld_q <= '0;
			end else if (add_s1) begin
				vld_q[col_s1] <= 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/ebs_ctrl.sv
`timescale 1ns / 1ps

module ebs_ctrl #(
	parameter int TABLE_ROWS = 1024,
	parameter int ROW_WIDTH = 16,
	parameter int TAW = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ebs_pkg::LEN_W-1:0]         cfg_wdata,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [1:0]                        item_opcode,
	input  logic [ebs_pkg::ROWIDX_W-1:0]      item_row_index,
	input  logic [ebs_pkg::COL_W-1:0]         item_column,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [ebs_pkg::COL_W-1:0]         res_column,
	output logic                              res_last,
	output logic                              tbl_wr,
	output logic [TAW-1:0]                    tbl_wr_addr,
	output logic                              tbl_rd,
	output logic [TAW-1:0]                    tbl_rd_addr,
	output ebs_pkg::acc_cmd_t                 acc_cmd
);
	import ebs_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ADD   = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_CRD   = 5'b01000,
		ST_COUT  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [LEN_W-1:0] row_length_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] len_active;
	logic [COL_W-1:0] col_q;
	logic [TAW-1:0]   base_q;
	logic             close_q;
	logic             accept;
	logic             row_ok;
	logic             col_ok;
	logic             at_end;
	opcode_t          op;

	assign op = opcode_t'(item_opcode);
	assign accept = item_valid && item_ready;
	assign item_ready = (state_q == ST_IDLE);
	assign row_ok = 32'(item_row_index) < TABLE_ROWS;
	assign col_ok = 32'(item_column) < ROW_WIDTH;
	assign at_end = {1'b0, col_q} == (len_q - 7'd1);

	always_comb begin
		if (row_length_q == '0) begin
			len_active = 7'd1;
		end else if (32'(row_length_q) > ROW_WIDTH) begin
			len_active = 7'(ROW_WIDTH);
		end else begin
			len_active = row_length_q;
		end
	end

	assign tbl_wr = accept && (op == OP_WRITE) && row_ok && col_ok;
	assign tbl_wr_addr = TAW'(32'(item_row_index) * ROW_WIDTH + 32'(item_column));
	assign tbl_rd = (state_q == ST_ADD);
	assign tbl_rd_addr = base_q + TAW'(col_q);

	assign res_valid = (state_q == ST_COUT);
	assign res_column = col_q;
	assign res_last = at_end;

	always_comb begin
		acc_cmd.rd = (state_q == ST_ADD) || (state_q == ST_CRD);
		acc_cmd.add = (state_q == ST_ADD);
		acc_cmd.clear = (state_q == ST_COUT) && res_ready && at_end;
		acc_cmd.col = col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RESET;
		end else if (cfg_we) begin
			row_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= '0;
			len_q <= 7'd1;
			close_q <= 1'b0;
			base_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						col_q <= '0;
						len_q <= len_active;
						close_q <= (op == OP_ADD_CLOSE) || (op == OP_CLOSE);
						base_q <= TAW'(32'(item_row_index) * ROW_WIDTH);
						case (op)
							OP_ADD: begin
								if (row_ok) begin
									state_q <= ST_ADD;
								end
							end
							OP_ADD_CLOSE: begin
								state_q <= row_ok ? ST_ADD : ST_CRD;
							end
							OP_CLOSE: begin
								state_q <= ST_CRD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_ADD: begin
					if (at_end) begin
						state_q <= ST_DRAIN;
					end else begin
						col_q <= col_q + 6'd1;
					end
				end
				ST_DRAIN: begin
					col_q <= '0;
					state_q <= close_q ? ST_CRD : ST_IDLE;
				end
				ST_CRD: begin
					state_q <= ST_COUT;
				end
				ST_COUT: begin
					if (res_ready) begin
						if (at_end) begin
							state_q <= ST_IDLE;
						end else begin
							col_q <= col_q + 6'd1;
							state_q <= ST_CRD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/embedding_bag_sum_forward.sv
// Embedding-bag sum over a table of signed Q8.8 words, TABLE_ROWS rows of ROW_WIDTH elements.
// A table write leaves the block idle. An add walks the used length (row_length clamped to
// 1..ROW_WIDTH): one saturating adder does a read-modify-write of one accumulator element per
// cycle. A close emits one result per used element (accumulator read, then the held result).
// The block takes no new transaction until the current one is done. Reading a table entry
// that was never written returns an undefined value.
`timescale 1ns / 1ps

module embedding_bag_sum_forward #(
	parameter int TABLE_ROWS = 1024,
	parameter int ROW_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ebs_pkg::LEN_W-1:0] cfg_wdata,
	ebs_item_if.sink                  item,
	ebs_result_if.source              result
);
	import ebs_pkg::*;

	localparam int DEPTH = TABLE_ROWS * ROW_WIDTH;
	localparam int TAW = $clog2(DEPTH);

	logic                    tbl_wr;
	logic [TAW-1:0]          tbl_wr_addr;
	logic                    tbl_rd;
	logic [TAW-1:0]          tbl_rd_addr;
	logic signed [VAL_W-1:0] tbl_data;
	acc_cmd_t                acc_cmd;

	ebs_ctrl #(
		.TABLE_ROWS(TABLE_ROWS),
		.ROW_WIDTH(ROW_WIDTH),
		.TAW(TAW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item_valid(item.valid),
		.item_ready(item.ready),
		.item_opcode(item.opcode),
		.item_row_index(item.row_index),
		.item_column(item.column),
		.res_valid(result.valid),
		.res_ready(result.ready),
		.res_column(result.column_res),
		.res_last(result.last),
		.tbl_wr(tbl_wr),
		.tbl_wr_addr(tbl_wr_addr),
		.tbl_rd(tbl_rd),
		.tbl_rd_addr(tbl_rd_addr),
		.acc_cmd(acc_cmd)
	);

	ebs_table_mem #(
		.DEPTH(DEPTH),
		.ADDR_W(TAW)
	) u_table (
		.clk(clk),
		.wr_en(tbl_wr),
		.wr_addr(tbl_wr_addr),
		.wr_data(item.value),
		.rd_en(tbl_rd),
		.rd_addr(tbl_rd_addr),
		.rd_data(tbl_data)
	);

	ebs_accum #(
		.ROW_WIDTH(ROW_WIDTH)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(acc_cmd),
		.tbl_data(tbl_data),
		.acc_value(result.sum)
	);

endmodule

// File: dv/tb_embedding_bag_sum_forward.sv
`timescale 1ns / 1ps

module tb_embedding_bag_sum_forward;
	import ebs_pkg::*;

	localparam int TABLE_ROWS = 1024;
	localparam int ROW_WIDTH = 16;
	localparam int ACC_WORDS = 64;
	localparam int BUSY_CYCLES = 40;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 310;
	localparam int PHASE_ITEMS = 45;
	localparam int REPORT_LIMIT = 10;
	localparam longint SUM_MAX = 64'sd2147483647;
	localparam longint SUM_MIN = -64'sd2147483648;
	localparam logic [ROWIDX_W-1:0] TOP_ROW = ROWIDX_W'(TABLE_ROWS - 1);

	typedef struct {
		logic signed [SUM_W-1:0] sum;
		logic [COL_W-1:0]        column;
		logic                    last;
	} bag_element_t;

	class bag_sum_scoreboard;
		logic signed [VAL_W-1:0] emb [TABLE_ROWS][ROW_WIDTH];
		logic signed [SUM_W-1:0] acc [ACC_WORDS];
		logic [LEN_W-1:0]        row_length;
		bag_element_t            pending_sums [$];
		int                      errors;

		function new();
			foreach (emb[r, c]) emb[r][c] = '0;
			foreach (acc[i]) acc[i] = '0;
			row_length = ROW_LENGTH_RESET;
			errors = 0;
		endfunction

		function int used_length();
			int n;
			n = row_length;
			if (n < 1) n = 1;
			if (n > ROW_WIDTH) n = ROW_WIDTH;
			return n;
		endfunction

		function void accumulate_row(logic [ROWIDX_W-1:0] row);
			longint s;
			if (row >= TABLE_ROWS) return;
			for (int c = 0; c < used_length(); c++) begin
				s = longint'(acc[c]) + longint'(emb[row][c]);
				if (s > SUM_MAX) s = SUM_MAX;
				if (s < SUM_MIN) s = SUM_MIN;
				acc[c] = SUM_W'(s);
			end
		endfunction

		function void close_bag();
			int n;
			bag_element_t e;
			n = used_length();
			for (int c = 0; c < n; c++) begin
				e.sum = acc[c];
				e.column = COL_W'(c);
				e.last = (c == n - 1);
				pending_sums.push_back(e);
			end
			foreach (acc[i]) acc[i] = '0;
		endfunction

		function void note_item(opcode_t op, logic [ROWIDX_W-1:0] row, logic [COL_W-1:0] col,
			logic signed [VAL_W-1:0] val);
			case (op)
				OP_WRITE: begin
					if (row < TABLE_ROWS && col < ROW_WIDTH) emb[row][col] = val;
				end
				OP_ADD: begin
					accumulate_row(row);
				end
				OP_ADD_CLOSE: begin
					accumulate_row(row);
					close_bag();
				end
				default: begin
					close_bag();
				end
			endcase
		endfunction

		function void note_failure(string msg);
			errors++;
			if (errors <= REPORT_LIMIT) $display("%s", msg);
		endfunction

		function void check_result(logic signed [SUM_W-1:0] sum, logic [COL_W-1:0] column,
			logic last);
			bag_element_t e;
			if (pending_sums.size() == 0) begin
				note_failure($sformatf("unexpected result: sum %0d column %0d last %0b",
					sum, column, last));
				return;
			end
			e = pending_sums.pop_front();
			if (sum !== e.sum || column !== e.column || last !== e.last)
				note_failure($sformatf({"result mismatch: expected sum %0d column %0d ",
					"last %0b, got sum %0d column %0d last %0b"},
					e.sum, e.column, e.last, sum, column, last));
		endfunction

		function int outstanding();
			return pending_sums.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	ebs_item_if item_ch();
	ebs_result_if result_ch();

	bag_sum_scoreboard sb;

	int cycle_count = 0;
	int rx_tick = 0;
	int rx_hold = 0;
	bit gaps_on;
	int burst_left;
	int random_count;
	int full_rows [$];
	bit row_loaded [TABLE_ROWS];
	int phase_lengths [8] = '{16, 127, 5, 1, 64, 9, 0, 3};

	embedding_bag_sum_forward #(
		.TABLE_ROWS(TABLE_ROWS),
		.ROW_WIDTH(ROW_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item(item_ch),
		.result(result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.row_length = cfg_wdata;
			if (item_ch.valid && item_ch.ready)
				sb.note_item(opcode_t'(item_ch.opcode), item_ch.row_index, item_ch.column,
					item_ch.value);
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.sum, result_ch.column_res, result_ch.last);
		end
	end

	// The receiver alternates stretches that start no new stalls with stretches of random stalls.
	always @(posedge clk) begin
		rx_tick++;
		if (rx_hold > 0) begin
			rx_hold--;
			result_ch.ready <= 1'b0;
		end else if (rx_tick[9:8] == 2'b01) begin
			result_ch.ready <= 1'b1;
		end else if ($urandom_range(0, 3) == 0) begin
			rx_hold = $urandom_range(0, 7);
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_embedding_bag_sum_forward NOT OK");
		$finish;
	end

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			3: return '1;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [ROWIDX_W-1:0] random_loaded_row();
		return ROWIDX_W'(full_rows[$urandom_range(0, full_rows.size() - 1)]);
	endfunction

	// Returns at the edge that accepts the transaction, with valid still high.
	task automatic send_item(opcode_t op, logic [ROWIDX_W-1:0] row, logic [COL_W-1:0] col,
		logic signed [VAL_W-1:0] val);
		if (gaps_on && burst_left == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= op;
		item_ch.row_index <= row;
		item_ch.column <= col;
		item_ch.value <= val;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		if (burst_left > 0) burst_left--;
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	task automatic program_length(logic [LEN_W-1:0] len);
		drain();
		repeat (BUSY_CYCLES) @(posedge clk);
		cfg_wdata <= len;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int quota);
		int done;
		int adds;
		int r;
		bit closing_add;
		done = 0;
		while (done < quota) begin
			if (full_rows.size() < 2 || $urandom_range(0, 5) == 0) begin
				r = $urandom_range(0, TABLE_ROWS - 1);
				for (int c = 0; c < ROW_WIDTH; c++) begin
					if ($urandom_range(0, 3) == 0)
						send_item(OP_WRITE, ROWIDX_W'($urandom),
							COL_W'($urandom_range(ROW_WIDTH, 63)), VAL_W'($urandom));
					send_item(OP_WRITE, ROWIDX_W'(r), COL_W'(c), pick_value());
				end
				if (!row_loaded[r]) begin
					row_loaded[r] = 1'b1;
					full_rows.push_back(r);
				end
				done += ROW_WIDTH;
			end else begin
				if ($urandom_range(0, 5) == 0) begin
					send_item(OP_WRITE, random_loaded_row(),
						COL_W'($urandom_range(0, ROW_WIDTH - 1)), pick_value());
					done++;
				end
				adds = $urandom_range(0, 4);
				closing_add = adds > 0 && $urandom_range(0, 1) == 1;
				for (int i = 0; i < adds; i++)
					send_item((closing_add && i == adds - 1) ? OP_ADD_CLOSE : OP_ADD,
						random_loaded_row(), COL_W'($urandom), VAL_W'($urandom));
				if (!closing_add)
					send_item(OP_CLOSE, ROWIDX_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
				done += adds + (closing_add ? 0 : 1);
				if ($urandom_range(0, 9) == 0) drain();
			end
		end
		// A bag may stay open across the next change of row length.
		repeat ($urandom_range(0, 2)) begin
			send_item(OP_ADD, random_loaded_row(), COL_W'($urandom), VAL_W'($urandom));
			done++;
		end
		random_count += done;
	endtask

	initial begin
		int phase;
		sb = new();
		item_ch.valid <= 1'b0;
		item_ch.opcode <= OP_WRITE;
		item_ch.row_index <= '0;
		item_ch.column <= '0;
		item_ch.value <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		gaps_on = 1'b1;
		burst_left = 0;
		random_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		send_item(OP_CLOSE, TOP_ROW, '0, '0);
		program_length(LEN_W'(0));
		send_item(OP_WRITE, '0, '0, 16'sh7FFF);
		send_item(OP_WRITE, TOP_ROW, '0, 16'sh8000);
		send_item(OP_WRITE, TOP_ROW, COL_W'(63), 16'sh5A5A);
		send_item(OP_WRITE, '0, COL_W'(ROW_WIDTH), 16'sh1234);
		send_item(OP_ADD, '0, '0, '0);
		send_item(OP_ADD_CLOSE, '0, '0, '0);
		send_item(OP_ADD, TOP_ROW, '0, '0);
		send_item(OP_ADD, TOP_ROW, '0, '0);
		send_item(OP_CLOSE, '0, '0, '0);
		program_length(LEN_W'(2));
		send_item(OP_WRITE, '0, COL_W'(1), 16'sh8000);
		send_item(OP_WRITE, TOP_ROW, COL_W'(1), 16'sh7FFF);
		send_item(OP_ADD, '0, '0, '0);
		program_length(LEN_W'(1));
		send_item(OP_ADD, TOP_ROW, '0, '0);
		program_length(LEN_W'(2));
		send_item(OP_ADD_CLOSE, '0, '0, '0);
		send_item(OP_ADD, TOP_ROW, '0, '0);
		program_length(LEN_W'(1));
		send_item(OP_CLOSE, '0, '0, '0);
		program_length(LEN_W'(2));
		send_item(OP_CLOSE, '0, '0, '0);

		phase = 0;
		while (random_count < RANDOM_ITEMS) begin
			if (phase < 8) program_length(LEN_W'(phase_lengths[phase]));
			else program_length(LEN_W'($urandom_range(0, 127)));
			run_phase(PHASE_ITEMS);
			phase++;
		end

		drain();
		repeat (BUSY_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("tb_embedding_bag_sum_forward OK");
		else
			$display("tb_embedding_bag_sum_forward NOT OK");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/ebs_pkg.sv
rtl/core/ebs_if.sv
rtl/core/ebs_table_mem.sv
rtl/core/ebs_accum.sv
rtl/core/ebs_ctrl.sv
rtl/core/embedding_bag_sum_forward.sv
dv/tb_embedding_bag_sum_forward.sv
